### rtl/core/assert_macros.svh
// assertion macros shared by the rtl files that check themselves
// no dependencies; expects signals named clk and rst where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define BLTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked at every edge, reset included
`define BLTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/bltc_pkg.sv
// types and constants of the bus load throttle controller
// no dependencies; used by every other rtl file but assert_macros.svh
package bltc_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned FramesW  = 17;
  localparam int unsigned WinW     = 16;
  localparam int unsigned RateW    = 20;
  localparam int unsigned FbitsW   = 8;
  localparam int unsigned LoadW    = 14;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned HystW    = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned DvdW     = 35;
  localparam int unsigned DsrW     = 32;
  localparam int unsigned Prod1W   = 25;

  localparam logic [LoadW-1:0]  LOAD_FULL = 14'd10000;
  localparam logic [TimeW-1:0]  ACT_HOLD  = 32'd1000;
  localparam logic [9:0]        MS_PER_S  = 10'd1000;
  localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic [LevelW-1:0] LEVEL_NORMAL = 2'd0;
  localparam logic [LevelW-1:0] LEVEL_LOW    = 2'd1;
  localparam logic [LevelW-1:0] LEVEL_EMERG  = 2'd2;

  typedef enum logic [1:0] {
    ACT_TX    = 2'd0,
    ACT_RX    = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_RESET = 2'd3
  } action_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_MS      = 3'd0,
    CFG_BIT_RATE       = 3'd1,
    CFG_FRAME_BITS     = 3'd2,
    CFG_HIGH_THRESHOLD = 3'd3,
    CFG_LOW_THRESHOLD  = 3'd4,
    CFG_RECOVER_MID    = 3'd5,
    CFG_RECOVER_LOW    = 3'd6,
    CFG_HYST_COUNT     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    action_t          kind;
    logic [TimeW-1:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [WinW-1:0]   window_ms;
    logic [RateW-1:0]  bit_rate;
    logic [FbitsW-1:0] frame_bits;
    logic [LoadW-1:0]  high_threshold;
    logic [LoadW-1:0]  low_threshold;
    logic [LoadW-1:0]  recover_mid;
    logic [LoadW-1:0]  recover_low;
    logic [HystW-1:0]  hyst_count;
  } cfg_t;

endpackage

### rtl/core/bltc_ifs.sv
// valid/ready channel interfaces: event items, results, register writes
// depends on bltc_pkg for field widths
interface bltc_item_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [bltc_pkg::TimeW-1:0]   now_ms;
  modport source (output valid, action, now_ms, input ready);
  modport sink   (input valid, action, now_ms, output ready);
endinterface

interface bltc_result_if;
  logic                          valid;
  logic                          ready;
  logic                          load_valid;
  logic [bltc_pkg::LoadW-1:0]    meas_load;
  logic [bltc_pkg::LevelW-1:0]   thr_level;
  modport source (output valid, load_valid, meas_load, thr_level, input ready);
  modport sink   (input valid, load_valid, meas_load, thr_level, output ready);
endinterface

interface bltc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bltc_pkg::CfgIdxW-1:0]  index;
  logic [bltc_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bus_load_throttle_controller_unit.sv
// bus load throttle controller, top level
// depends on bltc_pkg, the bltc interfaces, bltc_front, bltc_back, bltc_regs,
// and assert_macros.svh
//
// channels: item carries one event beat (action, now_ms); result returns one beat
// per event (load_valid, meas_load, thr_level); cfg writes one register per
// beat by index and is always ready
// a frame, bus reset or early evaluate beat writes its result register when it is
// taken; a window evaluation steps through MUL1 and MUL2, a restoring divide for
// bits per second, CHK and, unless the load caps, a second restoring divide for
// the load, then FIN writes the result
// throughput: one event at a time in the back end, so the divider sets the rate
// for evaluations; frame beats go at about one per cycle while the receiver is ready
// the front queue holds two beats, so the sender can place up to two beats while an
// evaluation runs or while the receiver stalls; a stalled result holds in its
// register and the back end takes no new beat until it is free
// reset: synchronous; counters, times, load and level clear, registers return
// to their defaults, the queue empties and no result is shown
`include "assert_macros.svh"

module bus_load_throttle_controller_unit (
  input  logic          clk,
  input  logic          rst,
  bltc_item_if.sink     item,
  bltc_result_if.source result,
  bltc_cfg_if.sink      cfg
);

  bltc_pkg::cfg_t regs;
  bltc_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;

  // register bank
  bltc_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // accept and classify, queue toward the back end
  bltc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // counting, evaluation and throttle
  bltc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .result    (result)
  );

  // a full queue always has a head waiting for the back end
  `BLTC_ASSERT(a_full_queue_has_head, !item.ready |-> cmd_valid, "full queue shows no head")
  // results never leave the legal load and level ranges
  `BLTC_ASSERT(a_load_range, result.valid |-> result.meas_load <= bltc_pkg::LOAD_FULL, "bad load")
  `BLTC_ASSERT(a_level_range, result.valid |-> result.thr_level <= bltc_pkg::LEVEL_EMERG, "bad level")
  // no result beat right after reset
  `BLTC_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !result.valid, "result valid after reset")

endmodule

### rtl/core/bltc_front.sv
// front end: takes event beats, classifies them, holds them in a two-entry queue
// depends on bltc_pkg and bltc_item_if
module bltc_front (
  input  logic            clk,
  input  logic            rst,
  bltc_item_if.sink       item,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output bltc_pkg::cmd_t  cmd
);

  localparam int unsigned QDepth = 2;

  bltc_pkg::cmd_t q_mem [QDepth];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;
  bltc_pkg::cmd_t in_cmd;

  assign item.ready = (count != 2'(QDepth));
  assign push       = item.valid && item.ready;
  assign pop        = cmd_valid && cmd_ready;
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = q_mem[rd_ptr];

  // classify the raw action code
  always_comb begin
    in_cmd.now_ms = item.now_ms;
    case (item.action)
      bltc_pkg::ACT_TX:   in_cmd.kind = bltc_pkg::ACT_TX;
      bltc_pkg::ACT_RX:   in_cmd.kind = bltc_pkg::ACT_RX;
      bltc_pkg::ACT_EVAL: in_cmd.kind = bltc_pkg::ACT_EVAL;
      default:            in_cmd.kind = bltc_pkg::ACT_RESET;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/bltc_div.sv
// restoring divider, one quotient bit per cycle
// depends on bltc_pkg for operand widths
module bltc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bltc_pkg::DvdW-1:0]  dividend,
  input  logic [bltc_pkg::DsrW-1:0]  divisor,
  output logic                       done,
  output logic [bltc_pkg::DvdW-1:0]  quotient
);

  localparam int unsigned CntW = $clog2(bltc_pkg::DvdW);
  localparam logic [CntW-1:0] LastStep = CntW'(bltc_pkg::DvdW - 1);

  logic                      busy;
  logic [CntW-1:0]           cnt;
  logic [bltc_pkg::DsrW-1:0] rem;
  logic [bltc_pkg::DsrW-1:0] dsr;
  logic [bltc_pkg::DvdW-1:0] quo;
  logic [bltc_pkg::DsrW:0]   rem_sh;
  logic [bltc_pkg::DsrW:0]   rem_diff;
  logic                      fits;

  assign rem_sh   = {rem, quo[bltc_pkg::DvdW-1]};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign fits     = (rem_sh >= {1'b0, dsr});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // one-cycle pulse after the last quotient bit
      done <= !start && busy && (cnt == LastStep);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= fits ? rem_diff[bltc_pkg::DsrW-1:0] : rem_sh[bltc_pkg::DsrW-1:0];
        quo <= {quo[bltc_pkg::DvdW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == LastStep) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### rtl/core/bltc_back.sv
// back end: frame counters, load evaluation, hysteresis throttle, result register
// depends on bltc_pkg, bltc_result_if and bltc_div
module bltc_back (
  input  logic                clk,
  input  logic                rst,
  input  bltc_pkg::cfg_t      cfg,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  bltc_pkg::cmd_t      cmd,
  bltc_result_if.source       result
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL1 = 7'b0000010,
    ST_MUL2 = 7'b0000100,
    ST_DIV1 = 7'b0001000,
    ST_CHK  = 7'b0010000,
    ST_DIV2 = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t state;

  logic [bltc_pkg::CountW-1:0] tx_frame_count;
  logic [bltc_pkg::CountW-1:0] rx_frame_count;
  logic [bltc_pkg::TimeW-1:0]  window_start_time;
  logic [bltc_pkg::TimeW-1:0]  last_activity_time;
  logic [bltc_pkg::HystW-1:0]  stable_count;
  logic [bltc_pkg::LevelW-1:0] level_now;
  logic [bltc_pkg::LoadW-1:0]  load_now;

  logic [bltc_pkg::TimeW-1:0]  now_r;
  logic [bltc_pkg::TimeW-1:0]  elapsed_r;
  logic                        act_r;
  logic [bltc_pkg::Prod1W-1:0] prod;
  logic [bltc_pkg::LoadW-1:0]  load_raw;

  logic                        res_valid;
  logic                        res_load_valid;
  logic [bltc_pkg::LoadW-1:0]  res_load;
  logic [bltc_pkg::LevelW-1:0] res_level;

  logic [bltc_pkg::TimeW-1:0]   elapsed;
  logic [bltc_pkg::WinW-1:0]    win_eff;
  logic [bltc_pkg::RateW-1:0]   rate_eff;
  logic                         act;
  logic [bltc_pkg::FramesW-1:0] frames;
  logic [bltc_pkg::Prod1W-1:0]  mul1;
  logic [bltc_pkg::DvdW-1:0]    mul2;
  logic [bltc_pkg::DvdW-1:0]    mul3;
  logic                         cap;
  logic                         div_start;
  logic [bltc_pkg::DvdW-1:0]    div_dividend;
  logic [bltc_pkg::DsrW-1:0]    div_divisor;
  logic                         div_done;
  logic [bltc_pkg::DvdW-1:0]    div_q;

  logic [bltc_pkg::LoadW-1:0]  load_fin;
  logic [bltc_pkg::HystW-1:0]  stable_inc;
  logic [bltc_pkg::LevelW-1:0] level_next;
  logic [bltc_pkg::HystW-1:0]  stable_next;
  logic                        counting;
  logic [bltc_pkg::LevelW-1:0] target;

  assign cmd_ready = (state == ST_IDLE) && (!res_valid || result.ready);

  assign result.valid      = res_valid;
  assign result.load_valid = res_load_valid;
  assign result.meas_load  = res_load;
  assign result.thr_level  = res_level;

  assign elapsed  = cmd.now_ms - window_start_time;
  assign win_eff  = (cfg.window_ms == '0) ? bltc_pkg::WinW'(1) : cfg.window_ms;
  assign rate_eff = (cfg.bit_rate == '0) ? bltc_pkg::RateW'(1) : cfg.bit_rate;
  assign act      = (last_activity_time != '0) &&
                    ((cmd.now_ms - last_activity_time) < bltc_pkg::ACT_HOLD);

  assign frames = bltc_pkg::FramesW'(tx_frame_count) + bltc_pkg::FramesW'(rx_frame_count);
  assign mul1   = bltc_pkg::Prod1W'(frames) * bltc_pkg::Prod1W'(cfg.frame_bits);
  assign mul2   = bltc_pkg::DvdW'(prod) * bltc_pkg::DvdW'(bltc_pkg::MS_PER_S);
  assign mul3   = bltc_pkg::DvdW'(div_q[bltc_pkg::RateW-1:0]) *
                  bltc_pkg::DvdW'(bltc_pkg::LOAD_FULL);
  // bps at or above the bit rate always lands on the cap
  assign cap    = (div_q >= bltc_pkg::DvdW'(rate_eff));

  assign div_start    = (state == ST_MUL2) || ((state == ST_CHK) && !cap);
  assign div_dividend = (state == ST_MUL2) ? mul2 : mul3;
  assign div_divisor  = (state == ST_MUL2) ? elapsed_r : bltc_pkg::DsrW'(rate_eff);

  bltc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // throttle decision on the finished load
  always_comb begin
    load_fin    = ((load_raw == '0) && act_r) ? bltc_pkg::LoadW'(1) : load_raw;
    stable_inc  = stable_count + 1'b1;
    level_next  = level_now;
    stable_next = stable_count;
    counting    = 1'b0;
    target      = bltc_pkg::LEVEL_NORMAL;
    if (load_fin >= cfg.high_threshold) begin
      level_next  = bltc_pkg::LEVEL_EMERG;
      stable_next = '0;
    end else if ((load_fin >= cfg.low_threshold) && (level_now < bltc_pkg::LEVEL_EMERG)) begin
      level_next  = bltc_pkg::LEVEL_LOW;
      stable_next = '0;
    end else if ((level_now == bltc_pkg::LEVEL_EMERG) && (load_fin < cfg.recover_mid)) begin
      counting = 1'b1;
      target   = bltc_pkg::LEVEL_LOW;
    end else if ((level_now == bltc_pkg::LEVEL_LOW) && (load_fin < cfg.recover_low)) begin
      counting = 1'b1;
      target   = bltc_pkg::LEVEL_NORMAL;
    end else if (load_fin < cfg.low_threshold) begin
      counting = 1'b1;
      target   = bltc_pkg::LEVEL_NORMAL;
    end
    if (counting) begin
      stable_next = stable_inc;
      if (stable_inc >= cfg.hyst_count) begin
        level_next  = target;
        stable_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      res_valid          <= 1'b0;
      tx_frame_count     <= '0;
      rx_frame_count     <= '0;
      window_start_time  <= '0;
      last_activity_time <= '0;
      stable_count       <= '0;
      level_now          <= '0;
      load_now           <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            now_r          <= cmd.now_ms;
            elapsed_r      <= elapsed;
            act_r          <= act;
            res_load_valid <= 1'b0;
            case (cmd.kind)
              bltc_pkg::ACT_TX: begin
                if (tx_frame_count != bltc_pkg::COUNT_MAX) begin
                  tx_frame_count <= tx_frame_count + 1'b1;
                end
                last_activity_time <= cmd.now_ms;
                res_load           <= load_now;
                res_level          <= level_now;
                res_valid          <= 1'b1;
              end
              bltc_pkg::ACT_RX: begin
                if (rx_frame_count != bltc_pkg::COUNT_MAX) begin
                  rx_frame_count <= rx_frame_count + 1'b1;
                end
                last_activity_time <= cmd.now_ms;
                res_load           <= load_now;
                res_level          <= level_now;
                res_valid          <= 1'b1;
              end
              bltc_pkg::ACT_EVAL: begin
                res_load  <= load_now;
                res_level <= level_now;
                if (elapsed >= bltc_pkg::TimeW'(win_eff)) begin
                  // any previous beat leaves at this edge
                  res_valid <= 1'b0;
                  state     <= ST_MUL1;
                end else begin
                  res_valid <= 1'b1;
                end
              end
              default: begin
                level_now          <= bltc_pkg::LEVEL_NORMAL;
                load_now           <= '0;
                window_start_time  <= cmd.now_ms;
                last_activity_time <= cmd.now_ms;
                res_load           <= '0;
                res_level          <= bltc_pkg::LEVEL_NORMAL;
                res_valid          <= 1'b1;
              end
            endcase
          end else if (result.ready) begin
            res_valid <= 1'b0;
          end
        end
        ST_MUL1: begin
          prod  <= mul1;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          state <= ST_DIV1;
        end
        ST_DIV1: begin
          if (div_done) begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (cap) begin
            load_raw <= bltc_pkg::LOAD_FULL;
            state    <= ST_FIN;
          end else begin
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            load_raw <= div_q[bltc_pkg::LoadW-1:0];
            state    <= ST_FIN;
          end
        end
        ST_FIN: begin
          load_now          <= load_fin;
          level_now         <= level_next;
          stable_count      <= stable_next;
          tx_frame_count    <= '0;
          rx_frame_count    <= '0;
          window_start_time <= now_r;
          res_valid         <= 1'b1;
          res_load_valid    <= 1'b1;
          res_load          <= load_fin;
          res_level         <= level_next;
          state             <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/bltc_top_dummy_placeholder_removed.sv
// configuration register bank of the bus load throttle controller
// depends on bltc_pkg and bltc_cfg_if
module bltc_regs (
  input  logic           clk,
  input  logic           rst,
  bltc_cfg_if.sink       cfg,
  output bltc_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.window_ms      <= 16'd100;
      regs.bit_rate       <= 20'd500000;
      regs.frame_bits     <= 8'd122;
      regs.high_threshold <= 14'd9000;
      regs.low_threshold  <= 14'd7000;
      regs.recover_mid    <= 14'd8500;
      regs.recover_low    <= 14'd6500;
      regs.hyst_count     <= 4'd5;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        bltc_pkg::CFG_WINDOW_MS:      regs.window_ms      <= cfg.data[bltc_pkg::WinW-1:0];
        bltc_pkg::CFG_BIT_RATE:       regs.bit_rate       <= cfg.data[bltc_pkg::RateW-1:0];
        bltc_pkg::CFG_FRAME_BITS:     regs.frame_bits     <= cfg.data[bltc_pkg::FbitsW-1:0];
        bltc_pkg::CFG_HIGH_THRESHOLD: regs.high_threshold <= cfg.data[bltc_pkg::LoadW-1:0];
        bltc_pkg::CFG_LOW_THRESHOLD:  regs.low_threshold  <= cfg.data[bltc_pkg::LoadW-1:0];
        bltc_pkg::CFG_RECOVER_MID:    regs.recover_mid    <= cfg.data[bltc_pkg::LoadW-1:0];
        bltc_pkg::CFG_RECOVER_LOW:    regs.recover_low    <= cfg.data[bltc_pkg::LoadW-1:0];
        bltc_pkg::CFG_HYST_COUNT:     regs.hyst_count     <= cfg.data[bltc_pkg::HystW-1:0];
        default:                      regs.hyst_count     <= regs.hyst_count;
      endcase
    end
  end

endmodule

### dv/tb.sv
// self-checking testbench for bus_load_throttle_controller_unit
// depends on bltc_pkg, the bltc channel interfaces and the rtl below them
// a tracker class mirrors the load meter and checks every result beat in order
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bltc_pkg::*;

  // what one result beat should carry
  typedef struct {
    logic              load_valid;
    logic [LoadW-1:0]  meas_load;
    logic [LevelW-1:0] level;
  } status_t;

  // mirror of the meter: registers, counters, window timing and throttle level;
  // every accepted event beat queues the status it must produce
  class load_tracker;
    logic [WinW-1:0]   window_ms;
    logic [RateW-1:0]  bit_rate;
    logic [FbitsW-1:0] frame_bits;
    logic [LoadW-1:0]  high_thr;
    logic [LoadW-1:0]  low_thr;
    logic [LoadW-1:0]  rec_mid;
    logic [LoadW-1:0]  rec_low;
    logic [HystW-1:0]  hyst_need;

    logic [CountW-1:0] tx_count;
    logic [CountW-1:0] rx_count;
    logic [TimeW-1:0]  win_start;
    logic [TimeW-1:0]  last_act;
    logic [HystW-1:0]  stable;
    logic [LevelW-1:0] level;
    logic [LoadW-1:0]  load;

    status_t status_due[$];
    int      errors;

    function new();
      window_ms  = 16'd100;
      bit_rate   = 20'd500000;
      frame_bits = 8'd122;
      high_thr   = 14'd9000;
      low_thr    = 14'd7000;
      rec_mid    = 14'd8500;
      rec_low    = 14'd6500;
      hyst_need  = 4'd5;
      tx_count   = '0;
      rx_count   = '0;
      win_start  = '0;
      last_act   = '0;
      stable     = '0;
      level      = LEVEL_NORMAL;
      load       = '0;
      errors     = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] d);
      case (idx)
        CFG_WINDOW_MS:      window_ms  = d[WinW-1:0];
        CFG_BIT_RATE:       bit_rate   = d[RateW-1:0];
        CFG_FRAME_BITS:     frame_bits = d[FbitsW-1:0];
        CFG_HIGH_THRESHOLD: high_thr   = d[LoadW-1:0];
        CFG_LOW_THRESHOLD:  low_thr    = d[LoadW-1:0];
        CFG_RECOVER_MID:    rec_mid    = d[LoadW-1:0];
        CFG_RECOVER_LOW:    rec_low    = d[LoadW-1:0];
        CFG_HYST_COUNT:     hyst_need  = d[HystW-1:0];
        default: ;
      endcase
    endfunction

    function void count_toward(logic [LevelW-1:0] target);
      stable = stable + 4'd1;
      if (stable >= hyst_need) begin
        level  = target;
        stable = '0;
      end
    endfunction

    function logic evaluate_window(logic [TimeW-1:0] t);
      logic [TimeW-1:0]  elapsed;
      logic [TimeW-1:0]  since_act;
      logic [WinW-1:0]   win;
      logic [RateW-1:0]  rate;
      logic [63:0]       frames;
      logic [63:0]       bps;
      logic [63:0]       full;
      logic [LoadW-1:0]  new_load;
      elapsed = t - win_start;
      win     = (window_ms == '0) ? 16'd1 : window_ms;
      rate    = (bit_rate == '0) ? 20'd1 : bit_rate;
      if (elapsed < {16'd0, win}) return 1'b0;
      frames = 64'(tx_count) + 64'(rx_count);
      bps    = frames * 64'(frame_bits) * 64'd1000 / 64'(elapsed);
      full   = bps * 64'(LOAD_FULL) / 64'(rate);
      if (full > 64'(LOAD_FULL)) full = 64'(LOAD_FULL);
      since_act = t - last_act;
      // recent activity keeps an idle-looking bus at the smallest nonzero load
      if (full == 64'd0 && last_act != '0 && since_act < ACT_HOLD) full = 64'd1;
      new_load = full[LoadW-1:0];
      load     = new_load;
      if (new_load >= high_thr) begin
        level  = LEVEL_EMERG;
        stable = '0;
      end else if (new_load >= low_thr && level < LEVEL_EMERG) begin
        level  = LEVEL_LOW;
        stable = '0;
      end else if (level == LEVEL_EMERG && new_load < rec_mid) begin
        count_toward(LEVEL_LOW);
      end else if (level == LEVEL_LOW && new_load < rec_low) begin
        count_toward(LEVEL_NORMAL);
      end else if (new_load < low_thr) begin
        count_toward(LEVEL_NORMAL);
      end
      tx_count  = '0;
      rx_count  = '0;
      win_start = t;
      return 1'b1;
    endfunction

    function void take_event(action_t a, logic [TimeW-1:0] t);
      status_t s;
      s.load_valid = 1'b0;
      case (a)
        ACT_TX: begin
          tx_count = (tx_count == COUNT_MAX) ? COUNT_MAX : tx_count + 16'd1;
          last_act = t;
        end
        ACT_RX: begin
          rx_count = (rx_count == COUNT_MAX) ? COUNT_MAX : rx_count + 16'd1;
          last_act = t;
        end
        ACT_EVAL: s.load_valid = evaluate_window(t);
        default: begin
          level     = LEVEL_NORMAL;
          load      = '0;
          win_start = t;
          last_act  = t;
        end
      endcase
      s.meas_load = load;
      s.level     = level;
      status_due.push_back(s);
    endfunction

    function void match_status(logic lv, logic [LoadW-1:0] ld, logic [LevelW-1:0] lvl);
      status_t e;
      if (status_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: result beat with no event waiting", $time);
        return;
      end
      e = status_due.pop_front();
      if (lv !== e.load_valid || ld !== e.meas_load || lvl !== e.level) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: lv exp %0d got %0d, load exp %0d got %0d, lvl exp %0d got %0d",
                   $time, e.load_valid, lv, e.meas_load, ld, e.level, lvl);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   idle_on;      // random gaps and stalls on both sides when set
  int   beats_sent;   // event beats accepted so far
  int   stall_left;   // receiver stall cycles still to run

  bltc_item_if   item_ch ();
  bltc_result_if res_ch ();
  bltc_cfg_if    cfg_ch ();

  load_tracker tr = new();

  bus_load_throttle_controller_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: mostly ready, short stalls now and then, a few long ones
  always @(posedge clk) begin : ready_gen
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!idle_on) begin
      res_ch.ready <= 1'b1;
    end else if (roll < 70) begin
      res_ch.ready <= 1'b1;
    end else if (roll < 92) begin
      res_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      res_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(8, 40);
    end
  end

  // every result beat taken is checked against the oldest queued status
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      tr.match_status(res_ch.load_valid, res_ch.meas_load, res_ch.thr_level);
  end

  // sender gap before a beat: mostly none, some short, a few long
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one event beat and hold it until the block takes it; valid stays
  // high into the next beat when there is no gap
  task automatic send_item(input action_t a, input logic [TimeW-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid  <= 1'b1;
    item_ch.action <= a;
    item_ch.now_ms <= t;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    tr.take_event(a, t);
    beats_sent++;
  endtask

  // one register write beat, then valid is dropped again
  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tr.write_reg(idx, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait until every queued status has come back
  task automatic settle(input int tail);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (tr.status_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // a register setting, then random frame and evaluate windows, noise, resets
  task automatic random_phase(input int p, input int n_beats);
    logic [CfgDataW-1:0] vals [8];
    logic [TimeW-1:0]    start;
    logic [TimeW-1:0]    t;
    longint unsigned     est;
    int unsigned         weff;
    int unsigned         nf;
    int unsigned         roll;
    int                  stop_at;
    int                  hold_at;
    settle(4);
    idle_on = (p != 2);
    case (p)
      0: begin
        // every register at its top
        vals[CFG_WINDOW_MS]      = 20'd65535;
        vals[CFG_BIT_RATE]       = 20'd1000000;
        vals[CFG_FRAME_BITS]     = 20'd255;
        vals[CFG_HIGH_THRESHOLD] = 20'd10000;
        vals[CFG_LOW_THRESHOLD]  = 20'd10000;
        vals[CFG_RECOVER_MID]    = 20'd10000;
        vals[CFG_RECOVER_LOW]    = 20'd10000;
        vals[CFG_HYST_COUNT]     = 20'd15;
      end
      1: begin
        // every register at its bottom
        vals[CFG_WINDOW_MS]      = 20'd1;
        vals[CFG_BIT_RATE]       = 20'd1;
        vals[CFG_FRAME_BITS]     = 20'd1;
        vals[CFG_HIGH_THRESHOLD] = 20'd0;
        vals[CFG_LOW_THRESHOLD]  = 20'd0;
        vals[CFG_RECOVER_MID]    = 20'd0;
        vals[CFG_RECOVER_LOW]    = 20'd0;
        vals[CFG_HYST_COUNT]     = 20'd1;
      end
      default: begin
        roll = $urandom_range(0, 99);
        if (roll < 5)       vals[CFG_WINDOW_MS] = 20'd0;
        else if (roll < 50) vals[CFG_WINDOW_MS] = $urandom_range(1, 40);
        else if (roll < 90) vals[CFG_WINDOW_MS] = $urandom_range(41, 1500);
        else                vals[CFG_WINDOW_MS] = $urandom_range(1501, 65535);
        vals[CFG_FRAME_BITS] = $urandom_range(1, 255);
        weff = (vals[CFG_WINDOW_MS] == '0) ? 1 : vals[CFG_WINDOW_MS];
        // pick a bit rate that puts a handful of frames near the thresholds
        est = 64'd6 * vals[CFG_FRAME_BITS] * 64'd1000 / weff;
        est = est * $urandom_range(30, 300) / 100;
        if (est < 1) est = 1;
        if (est > 1000000) est = 1000000;
        vals[CFG_BIT_RATE] = est[CfgDataW-1:0];
        if ($urandom_range(0, 3) == 0) begin
          vals[CFG_HIGH_THRESHOLD] = $urandom_range(0, 10000);
          vals[CFG_LOW_THRESHOLD]  = $urandom_range(0, 10000);
          vals[CFG_RECOVER_MID]    = $urandom_range(0, 10000);
          vals[CFG_RECOVER_LOW]    = $urandom_range(0, 10000);
        end else begin
          vals[CFG_HIGH_THRESHOLD] = $urandom_range(5000, 10000);
          vals[CFG_LOW_THRESHOLD]  = $urandom_range(2000, vals[CFG_HIGH_THRESHOLD]);
          vals[CFG_RECOVER_MID]    = $urandom_range(vals[CFG_LOW_THRESHOLD],
                                                    vals[CFG_HIGH_THRESHOLD]);
          vals[CFG_RECOVER_LOW]    = $urandom_range(0, vals[CFG_LOW_THRESHOLD]);
        end
        vals[CFG_HYST_COUNT] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                           : $urandom_range(0, 3);
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), vals[i]);

    stop_at = beats_sent + n_beats;
    hold_at = (p == 3) ? beats_sent + n_beats / 2 : -1;
    while (beats_sent < stop_at) begin
      // once mid-phase the sender holds off until the block has drained
      if (hold_at >= 0 && beats_sent >= hold_at) begin
        settle(0);
        hold_at = -1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: any action at any tick
        send_item(action_t'($urandom_range(0, 3)), $urandom());
      end else if (roll < 14) begin
        // bus reset, sometimes just before the tick wraps
        case ($urandom_range(0, 2))
          0:       t = $urandom();
          1:       t = 32'hFFFF_FFFF - $urandom_range(0, 500);
          default: t = tr.win_start + $urandom_range(0, 3000);
        endcase
        send_item(ACT_RESET, t);
      end else begin
        // well-formed window: frames inside it, maybe an early evaluate,
        // then an evaluate once the window has run out
        start = tr.win_start;
        weff  = (tr.window_ms == '0) ? 1 : tr.window_ms;
        nf    = $urandom_range(0, 10);
        repeat (nf)
          send_item($urandom_range(0, 1) ? ACT_TX : ACT_RX, start + $urandom_range(0, weff));
        if (weff > 1 && $urandom_range(0, 4) == 0)
          send_item(ACT_EVAL, start + $urandom_range(0, weff - 1));
        send_item(ACT_EVAL, start + weff + $urandom_range(0, weff / 2));
      end
    end
  endtask

  initial begin
    item_ch.valid  = 1'b0;
    item_ch.action = ACT_TX;
    item_ch.now_ms = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_WINDOW_MS;
    cfg_ch.data    = '0;
    res_ch.ready   = 1'b0;
    stall_left     = 0;
    beats_sent     = 0;
    idle_on        = 1'b1;
    rst            = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset: evaluate before the window ends, frames at the
    // tick extremes, a bus reset, and an elapsed time that wraps
    send_item(ACT_EVAL,  32'd50);
    send_item(ACT_TX,    32'd0);
    send_item(ACT_RX,    32'hFFFF_FFFF);
    send_item(ACT_EVAL,  32'd100);
    send_item(ACT_RESET, 32'h8000_0000);
    send_item(ACT_EVAL,  32'h7FFF_FFFF);

    // zero window, zero bit rate and zero hysteresis; recent activity lifts
    // an empty window to the smallest load; capped load enters emergency,
    // then two quiet windows drop one level each
    settle(4);
    write_reg(CFG_WINDOW_MS,  20'd0);
    write_reg(CFG_BIT_RATE,   20'd0);
    write_reg(CFG_FRAME_BITS, 20'd255);
    write_reg(CFG_HYST_COUNT, 20'd0);
    send_item(ACT_TX,   32'd10);
    send_item(ACT_EVAL, 32'd10);
    send_item(ACT_EVAL, 32'd10);
    send_item(ACT_EVAL, 32'd11);
    send_item(ACT_TX,   32'd11);
    send_item(ACT_RX,   32'd11);
    send_item(ACT_EVAL, 32'd12);
    send_item(ACT_EVAL, 32'd2000);
    send_item(ACT_EVAL, 32'd2001);

    // longest window: one tick short, then exactly elapsed
    settle(4);
    write_reg(CFG_HIGH_THRESHOLD, 20'd10000);
    write_reg(CFG_LOW_THRESHOLD,  20'd10000);
    write_reg(CFG_RECOVER_MID,    20'd0);
    write_reg(CFG_RECOVER_LOW,    20'd0);
    write_reg(CFG_HYST_COUNT,     20'd15);
    write_reg(CFG_WINDOW_MS,      20'd65535);
    write_reg(CFG_BIT_RATE,       20'd1000000);
    write_reg(CFG_FRAME_BITS,     20'd1);
    send_item(ACT_TX,   32'd2001);
    send_item(ACT_EVAL, 32'd67535);
    send_item(ACT_EVAL, 32'd67536);

    // products past 32 bits: load caps exactly at the high threshold
    settle(4);
    write_reg(CFG_WINDOW_MS,  20'd1);
    write_reg(CFG_FRAME_BITS, 20'd255);
    send_item(ACT_RESET, 32'd70000);
    send_item(ACT_TX,    32'd70000);
    send_item(ACT_TX,    32'd70000);
    send_item(ACT_RX,    32'd70000);
    send_item(ACT_RX,    32'd70000);
    send_item(ACT_EVAL,  32'd70001);

    for (int p = 0; p < 7; p++) random_phase(p, 85);

    // drain, then give a slow evaluation time to show anything stray
    settle(120);
    if (tr.status_due.size() != 0) begin
      tr.errors++;
      $display("%0t: %0d results never arrived", $time, tr.status_due.size());
    end
    if (tr.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far past the slowest legal run
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
